// ===== rtl/les_pkg.sv =====
// Shared types and constants for the LED effect sequencer.
package les_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_JUMP    = 2'd1,
    MODE_DEATH   = 2'd2,
    MODE_RAINBOW = 2'd3
  } mode_t;

  // Color source picked for a tick once the effect state is resolved
  typedef enum logic [2:0] {
    SRC_BLACK   = 3'd0,
    SRC_DIM     = 3'd1,
    SRC_BREATH  = 3'd2,
    SRC_JUMP    = 3'd3,
    SRC_DEATH   = 3'd4,
    SRC_RAINBOW = 3'd5
  } src_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [31:0] JUMP_MS    = 32'd200;
  localparam logic [31:0] DEATH_MS   = 32'd1200;
  localparam logic [31:0] RAINBOW_MS = 32'd3000;

  localparam logic [7:0] DIM_R = 8'd8;
  localparam logic [7:0] DIM_G = 8'd8;
  localparam logic [7:0] DIM_B = 8'd16;

  localparam logic [7:0] BREATH_BASE = 8'd20;

endpackage

// ===== rtl/les_if.sv =====
// Valid/ready channel interfaces for sequencer input items and colors.
interface les_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic        just_jumped;
  logic        just_died;
  logic        new_best;
  logic        playing;
  logic [31:0] now_ms;

  modport source (output valid, output operation, output just_jumped, output just_died,
                  output new_best, output playing, output now_ms, input ready);
  modport sink   (input valid, input operation, input just_jumped, input just_died,
                  input new_best, input playing, input now_ms, output ready);
endinterface

interface les_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/led_effect_sequencer_core.sv =====
// Top level of the LED effect sequencer: effect state and color pipeline.
//
//  channel   | dir | payload                                             | role
//  in_chan   | in  | operation just_jumped just_died new_best playing now_ms | event or tick
//  out_chan  | out | red green blue                                      | one color per tick
//
// One item per cycle unless the output stalls; a tick's color runs through the
// 17-deep pipeline (input register, constant-reciprocal divides, breathing index,
// sine polynomial steps, output register).
// Events update the effect state at the first stage and give no color.
// Reset clears the effect state to idle with start time zero and empties the pipe.
// A stalled output freezes the whole pipe; in_chan.ready follows it.
module led_effect_sequencer_core #(
  parameter int BREATH_TABLE_DEPTH = 256
) (
  input logic clk,
  input logic rst_n,
  les_in_if.sink   in_chan,
  les_out_if.source out_chan
);
  import les_pkg::*;

  localparam int KW   = $clog2(BREATH_TABLE_DEPTH);
  localparam int LAST = 16;

  localparam logic [26:0] RECIP_2000  = 27'd68719476;  // floor(2^37 / 2000)
  localparam logic [18:0] RECIP_200   = 19'd335544;    // floor(2^26 / 200)
  localparam logic [19:0] RECIP_1200  = 20'd894784;    // floor(2^30 / 1200)
  localparam logic [11:0] DEPTH_W     = 12'(BREATH_TABLE_DEPTH);
  localparam logic [12:0] TURN_STEP   = 13'(65536 / BREATH_TABLE_DEPTH);
  localparam logic [10:0] TURN_REM    = 11'(65536 % BREATH_TABLE_DEPTH);
  localparam logic [28:0] RECIP_DEPTH = 29'((64'd1 << 32) / BREATH_TABLE_DEPTH);

  logic            adv;
  logic [LAST:0]   v_r;

  // input register
  logic        s0_op_r, s0_jump_r, s0_died_r, s0_best_r, s0_play_r;
  logic [31:0] s0_now_r;

  // effect state
  mode_t       mode_r, mode_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] elapsed;
  src_t        src_nxt;

  logic [11:0] s1_e_r, s2_e_r, s3_e_r;
  src_t        s1_src_r, s2_src_r, s3_src_r;
  logic [31:0] s1_now_r;
  logic [26:0] s2_x_r, s3_x_r;
  logic [19:0] s2_y_r, s3_y_r;
  logic [15:0] s3_xq_r;
  logic [12:0] s3_qj_r, s3_qd_r;

  logic [26:0] r0;
  logic [10:0] r_nxt, s4_r_r;
  logic [19:0] rem_j, rem_d;
  logic [12:0] qj, qd;
  logic [7:0]  wp, wq, ww, w3;
  rgb_t        fx_nxt;

  rgb_t        fx_r   [4:15];
  logic        brth_r [4:15];

  logic [21:0]   s5_y2_r, s6_y2_r;
  logic [KW:0]   s6_k0_r;
  logic [21:0]   rem_k;
  logic [KW:0]   k_sum;
  logic [KW-1:0] s7_k_r;
  logic [16:0]   s8_ka_r, s9_ka_r;
  logic [21:0]   s8_kb_r, s9_kb_r;
  logic [11:0]   s9_tq_r;
  logic [21:0]   rem_t;
  logic [16:0]   t_sum;
  logic [16:0]   u_nxt;

  logic [16:0] u_r   [10:14];
  logic        neg_r [10:15];
  logic [16:0] u2_r  [11:13];
  logic [12:0] s12_p1_r;
  logic [15:0] s13_p2_r;
  logic [16:0] s14_p3_r;
  logic [16:0] s15_mag_r;

  logic [17:0] m_lvl;
  logic [7:0]  level;
  rgb_t        out_rgb_r, out_nxt;

  // advance whenever the output register is empty or being drained
  assign adv           = !v_r[LAST] || out_chan.ready;
  assign in_chan.ready = adv;
  assign out_chan.valid = v_r[LAST];
  assign out_chan.red   = out_rgb_r.red;
  assign out_chan.green = out_rgb_r.green;
  assign out_chan.blue  = out_rgb_r.blue;

  // stage 0: resolve effect state for the item in the input register
  always_comb begin
    mode_nxt  = mode_r;
    start_nxt = start_r;
    src_nxt   = SRC_BLACK;
    elapsed   = s0_now_r - start_r;
    if (v_r[0]) begin
      if (s0_op_r == OP_EVENT) begin
        if (s0_died_r) begin
          mode_nxt  = s0_best_r ? MODE_RAINBOW : MODE_DEATH;
          start_nxt = s0_now_r;
        end else if (s0_jump_r) begin
          mode_nxt  = MODE_JUMP;
          start_nxt = s0_now_r;
        end
      end else begin
        case (mode_r)
          MODE_JUMP: begin
            if (elapsed > JUMP_MS) mode_nxt = MODE_IDLE;
            else src_nxt = SRC_JUMP;
          end
          MODE_DEATH: begin
            if (elapsed > DEATH_MS) mode_nxt = MODE_IDLE;
            else src_nxt = SRC_DEATH;
          end
          MODE_RAINBOW: begin
            if (elapsed > RAINBOW_MS) mode_nxt = MODE_IDLE;
            else src_nxt = SRC_RAINBOW;
          end
          MODE_IDLE: src_nxt = s0_play_r ? SRC_BREATH : SRC_DIM;
          default:   src_nxt = SRC_BLACK;
        endcase
      end
    end
  end

  // stage 3 -> 4: finish the divides and build effect colors
  always_comb begin
    r0    = s3_x_r - 27'(s3_xq_r) * 27'd2000;
    r_nxt = (r0 >= 27'd2000) ? 11'(r0 - 27'd2000) : 11'(r0);

    rem_j = s3_y_r - 20'(s3_qj_r) * 20'd200;
    qj    = s3_qj_r + ((rem_j >= 20'd200) ? 13'd1 : 13'd0);
    rem_d = s3_y_r - 20'(s3_qd_r) * 20'd1200;
    qd    = s3_qd_r + ((rem_d >= 20'd1200) ? 13'd1 : 13'd0);

    wp = s3_e_r[10:3];
    wq = 8'd255 - wp;
    if (wq < 8'd85)       ww = wq;
    else if (wq < 8'd170) ww = wq - 8'd85;
    else                  ww = wq - 8'd170;
    w3 = 8'(10'(ww) * 10'd3);

    fx_nxt = '0;
    case (s3_src_r)
      SRC_DIM:   fx_nxt = '{red: DIM_R, green: DIM_G, blue: DIM_B};
      SRC_JUMP:  fx_nxt.blue = 8'd255 - qj[7:0];
      SRC_DEATH: fx_nxt.red  = 8'd255 - qd[7:0];
      SRC_RAINBOW: begin
        if (wq < 8'd85)       fx_nxt = '{red: 8'd255 - w3, green: 8'd0, blue: w3};
        else if (wq < 8'd170) fx_nxt = '{red: 8'd0, green: w3, blue: 8'd255 - w3};
        else                  fx_nxt = '{red: w3, green: 8'd255 - w3, blue: 8'd0};
      end
      default: fx_nxt = '0;
    endcase
  end

  // breathing index and turn fraction
  always_comb begin
    rem_k = s6_y2_r - 22'(s6_k0_r) * 22'd2000;
    k_sum = s6_k0_r + ((rem_k >= 22'd2000) ? (KW+1)'(1) : (KW+1)'(0));
    rem_t = s9_kb_r - 22'(s9_tq_r) * 22'(DEPTH_W);
    t_sum = s9_ka_r + 17'(s9_tq_r) + ((rem_t >= 22'(DEPTH_W)) ? 17'd1 : 17'd0);
    // odd quadrants mirror the quarter wave
    if (t_sum[14]) u_nxt = 17'(15'd16384 - {1'b0, t_sum[13:0]}) << 2;
    else           u_nxt = 17'(t_sum[13:0]) << 2;
  end

  // output stage: level from the sine magnitude
  always_comb begin
    if (neg_r[15]) m_lvl = (s15_mag_r >= 17'd65536) ? 18'd0 : 18'd65536 - 18'(s15_mag_r);
    else           m_lvl = 18'd65536 + 18'(s15_mag_r);
    level = BREATH_BASE + 8'((24'(m_lvl) * 24'd40) >> 17);
    if (brth_r[15]) out_nxt = '{red: 8'd0, green: level, blue: level};
    else            out_nxt = fx_r[15];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      mode_r  <= MODE_IDLE;
      start_r <= '0;
    end else if (adv) begin
      v_r[0] <= in_chan.valid;
      v_r[1] <= v_r[0] && (s0_op_r == OP_TICK);
      for (int i = 2; i <= LAST; i++) v_r[i] <= v_r[i-1];
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_op_r   <= in_chan.operation;
      s0_jump_r <= in_chan.just_jumped;
      s0_died_r <= in_chan.just_died;
      s0_best_r <= in_chan.new_best;
      s0_play_r <= in_chan.playing;
      s0_now_r  <= in_chan.now_ms;

      s1_src_r <= src_nxt;
      s1_e_r   <= elapsed[11:0];
      s1_now_r <= s0_now_r;

      s2_src_r <= s1_src_r;
      s2_e_r   <= s1_e_r;
      s2_x_r   <= 27'(s1_now_r[31:16]) * 27'd1536 + 27'(s1_now_r[15:0]);
      s2_y_r   <= 20'(s1_e_r) * 20'd255;

      s3_src_r <= s2_src_r;
      s3_e_r   <= s2_e_r;
      s3_x_r   <= s2_x_r;
      s3_y_r   <= s2_y_r;
      s3_xq_r  <= 16'((54'(s2_x_r) * 54'(RECIP_2000)) >> 37);
      s3_qj_r  <= 13'((39'(s2_y_r) * 39'(RECIP_200)) >> 26);
      s3_qd_r  <= 13'((40'(s2_y_r) * 40'(RECIP_1200)) >> 30);

      s4_r_r    <= r_nxt;
      fx_r[4]   <= fx_nxt;
      brth_r[4] <= (s3_src_r == SRC_BREATH);
      for (int i = 5; i <= 15; i++) begin
        fx_r[i]   <= fx_r[i-1];
        brth_r[i] <= brth_r[i-1];
      end

      s5_y2_r <= 22'(s4_r_r) * 22'(DEPTH_W);
      s6_y2_r <= s5_y2_r;
      s6_k0_r <= (KW+1)'((49'(s5_y2_r) * 49'(RECIP_2000)) >> 37);
      s7_k_r  <= k_sum[KW-1:0];

      s8_ka_r <= 17'(s7_k_r) * 17'(TURN_STEP);
      s8_kb_r <= 22'(s7_k_r) * 22'(TURN_REM);
      s9_ka_r <= s8_ka_r;
      s9_kb_r <= s8_kb_r;
      s9_tq_r <= 12'((51'(s8_kb_r) * 51'(RECIP_DEPTH)) >> 32);

      u_r[10]   <= u_nxt;
      neg_r[10] <= t_sum[15];
      for (int i = 11; i <= 14; i++) u_r[i] <= u_r[i-1];
      for (int i = 11; i <= 15; i++) neg_r[i] <= neg_r[i-1];

      u2_r[11] <= 17'((34'(u_r[10]) * 34'(u_r[10])) >> 16);
      u2_r[12] <= u2_r[11];
      u2_r[13] <= u2_r[12];

      s12_p1_r  <= 13'(14'd5223 - 14'((26'(u2_r[11]) * 26'd297) >> 16));
      s13_p2_r  <= 16'd42334 - 16'((30'(s12_p1_r) * 30'(u2_r[12])) >> 16);
      s14_p3_r  <= 17'd102944 - 17'((33'(s13_p2_r) * 33'(u2_r[13])) >> 16);
      s15_mag_r <= 17'((34'(s14_p3_r) * 34'(u_r[14])) >> 16);

      out_rgb_r <= out_nxt;
    end
  end

endmodule

// ===== rtl/les_checker.sv =====
// Port-level checks for the LED effect sequencer, bound to its top level.
module les_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);
  import les_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("color dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({red, green, blue}))
    else $error("color changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held off with an empty output");

  a_freeze_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while the pipe is frozen");

  // every color has a dark channel except the dim idle color
  a_color_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (red == 8'd0 || green == 8'd0 || blue == 8'd0 ||
                   (red == DIM_R && green == DIM_G && blue == DIM_B)))
    else $error("color outside every effect");

endmodule

bind led_effect_sequencer_core les_checker u_les_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .red       (out_chan.red),
  .green     (out_chan.green),
  .blue      (out_chan.blue)
);

// ===== bench/tb_led_effect_sequencer_core.sv =====
// Self-checking testbench for the LED effect sequencer: directed effects, then random traffic.
module tb_led_effect_sequencer_core;
  import les_pkg::*;

  localparam int BREATH_DEPTH = 256;

  logic clk = 1'b0;
  logic rst_n;

  les_in_if  in_chan();
  les_out_if out_chan();

  led_effect_sequencer_core #(.BREATH_TABLE_DEPTH(BREATH_DEPTH)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted effect state and the colors still owed by the block
  mode_t       fx_mode;
  logic [31:0] fx_start_ms;
  rgb_t        color_q[$];
  int          err_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic [31:0] now_cur;

  function automatic longint unsigned quarter_sine_q16(input longint unsigned u);
    longint unsigned u2, p;
    u2 = (u * u) >> 16;
    p  = 5223 - ((297 * u2) >> 16);
    p  = 42334 - ((p * u2) >> 16);
    p  = 102944 - ((p * u2) >> 16);
    return (p * u) >> 16;
  endfunction

  function automatic logic [7:0] breath_level(input logic [31:0] now);
    longint unsigned ms, k, t, quad, r, mag, m;
    ms   = now % 32'd2000;
    k    = (ms * BREATH_DEPTH) / 2000;
    t    = (k * 65536) / BREATH_DEPTH;
    quad = (t >> 14) & 3;
    r    = t & 16'h3FFF;
    if (quad == 0 || quad == 2) begin
      mag = quarter_sine_q16(r << 2);
    end else begin
      mag = quarter_sine_q16((16384 - r) << 2);
    end
    if (quad >= 2) begin
      m = (mag >= 65536) ? 0 : 65536 - mag;
    end else begin
      m = 65536 + mag;
    end
    return 8'(BREATH_BASE + ((40 * m) >> 17));
  endfunction

  function automatic rgb_t wheel_color(input logic [7:0] pos);
    int   q;
    rgb_t c;
    q = 255 - pos;
    if (q < 85) begin
      c = '{red: 8'(255 - 3 * q), green: 8'd0, blue: 8'(3 * q)};
    end else if (q < 170) begin
      q = q - 85;
      c = '{red: 8'd0, green: 8'(3 * q), blue: 8'(255 - 3 * q)};
    end else begin
      q = q - 170;
      c = '{red: 8'(3 * q), green: 8'(255 - 3 * q), blue: 8'd0};
    end
    return c;
  endfunction

  // Advance the effect state for one accepted item; queue a color for a tick
  task automatic apply_led_item(input logic op, input logic jumped, input logic died,
                                input logic best, input logic playing,
                                input logic [31:0] now);
    logic [31:0] e;
    rgb_t        c;
    if (op == OP_EVENT) begin
      if (died) begin
        fx_mode     = best ? MODE_RAINBOW : MODE_DEATH;
        fx_start_ms = now;
      end else if (jumped) begin
        fx_mode     = MODE_JUMP;
        fx_start_ms = now;
      end
    end else begin
      e = now - fx_start_ms;
      c = '0;
      case (fx_mode)
        MODE_JUMP: begin
          if (e > JUMP_MS) fx_mode = MODE_IDLE;
          else c.blue = 8'(32'd255 - (e * 32'd255) / 32'd200);
        end
        MODE_DEATH: begin
          if (e > DEATH_MS) fx_mode = MODE_IDLE;
          else c.red = 8'(32'd255 - (e * 32'd255) / 32'd1200);
        end
        MODE_RAINBOW: begin
          if (e > RAINBOW_MS) fx_mode = MODE_IDLE;
          else c = wheel_color(e[10:3]);
        end
        default: begin
          if (playing) begin
            c.green = breath_level(now);
            c.blue  = c.green;
          end else begin
            c = '{red: DIM_R, green: DIM_G, blue: DIM_B};
          end
        end
      endcase
      color_q.push_back(c);
    end
  endtask

  // Called right after a rising edge; returns right after the edge of the transfer
  // or after the idle cycles that follow it
  task automatic send_item(input logic op, input logic jumped, input logic died,
                           input logic best, input logic playing, input logic [31:0] now);
    in_chan.valid       <= 1'b1;
    in_chan.operation   <= op;
    in_chan.just_jumped <= jumped;
    in_chan.just_died   <= died;
    in_chan.new_best    <= best;
    in_chan.playing     <= playing;
    in_chan.now_ms      <= now;
    do @(posedge clk); while (!in_chan.ready);
    apply_led_item(op, jumped, died, best, playing, now);
    if ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_tick(input logic playing, input logic [31:0] now);
    send_item(OP_TICK, 1'b0, 1'b0, 1'b0, playing, now);
  endtask

  task automatic send_event(input logic jumped, input logic died, input logic best,
                            input logic [31:0] now);
    send_item(OP_EVENT, jumped, died, best, 1'b0, now);
  endtask

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (color_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected color r=%0d g=%0d b=%0d", $time,
                 out_chan.red, out_chan.green, out_chan.blue);
      end else begin
        want = color_q.pop_front();
        if (out_chan.red !== want.red) begin
          err_count++;
          $display("%0t: red expected %0d actual %0d", $time, want.red, out_chan.red);
        end
        if (out_chan.green !== want.green) begin
          err_count++;
          $display("%0t: green expected %0d actual %0d", $time, want.green, out_chan.green);
        end
        if (out_chan.blue !== want.blue) begin
          err_count++;
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, out_chan.blue);
        end
      end
    end
  end

  task automatic test_idle_colors();
    send_tick(1'b0, 32'd0);
    send_tick(1'b0, 32'hFFFF_FFFF);
    send_tick(1'b1, 32'd0);
    send_tick(1'b1, 32'd500);
    send_tick(1'b1, 32'd1000);
    send_tick(1'b1, 32'd1500);
    send_tick(1'b1, 32'hFFFF_FFFF);
  endtask

  // Fade ends exactly at the limit; one past it gives black, then idle again
  task automatic test_jump_flash();
    send_event(1'b1, 1'b0, 1'b1, 32'd5000);
    send_tick(1'b1, 32'd5000);
    send_tick(1'b1, 32'd5200);
    send_tick(1'b1, 32'd5201);
    send_tick(1'b0, 32'd5202);
  endtask

  task automatic test_death_fade();
    send_event(1'b1, 1'b1, 1'b0, 32'd7000);
    send_tick(1'b0, 32'd7600);
    send_tick(1'b0, 32'd8200);
    send_tick(1'b1, 32'd8201);
  endtask

  task automatic test_rainbow();
    send_event(1'b0, 1'b1, 1'b1, 32'd10000);
    send_tick(1'b0, 32'd10000);
    send_tick(1'b0, 32'd13000);
    send_tick(1'b0, 32'd13001);
  endtask

  // Empty event, event fields on a tick, and elapsed time across the wrap
  task automatic test_wrap_and_ignored();
    send_event(1'b1, 1'b0, 1'b0, 32'hFFFF_FFC0);
    send_event(1'b0, 1'b0, 1'b1, 32'd3);
    send_item(OP_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 32'h0000_0024);
    send_tick(1'b0, 32'h0000_0100);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
    int          sel;
    logic [31:0] now;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if ($urandom_range(99) == 0) begin
        now_cur = 32'hFFFF_FFFF - $urandom_range(0, 500);
      end
      now_cur += ($urandom_range(3) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 60);
      now = (sel < 8) ? $urandom : now_cur;
      if (sel < 25) begin
        send_item(sel[0], 1'($urandom), $urandom_range(2) == 0, 1'($urandom),
                  1'($urandom), now);
      end else if (sel < 40) begin
        send_event(1'($urandom), $urandom_range(1) == 0, 1'($urandom), now);
      end else begin
        send_item(OP_TICK, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), now);
      end
    end
  endtask

  initial begin
    fx_mode             = MODE_IDLE;
    fx_start_ms         = '0;
    err_count           = 0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    now_cur             = 32'd20000;
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.operation   = OP_EVENT;
    in_chan.just_jumped = 1'b0;
    in_chan.just_died   = 1'b0;
    in_chan.new_best    = 1'b0;
    in_chan.playing     = 1'b0;
    in_chan.now_ms      = '0;
    out_chan.ready      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_colors();
    test_jump_flash();
    test_death_fade();
    test_rainbow();
    test_wrap_and_ignored();
    test_random_phase(0, 0, 125);
    test_random_phase(57, 0, 125);
    test_random_phase(0, 57, 125);
    test_random_phase(35, 35, 125);

    in_chan.valid <= 1'b0;
    recv_stall_pct = 0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule
